/* src/hptn_pkg.sv */
// hptn_pkg: shared types and constants for the histogram peak top-n block
// no dependencies; used by hptn_ctrl, hptn_datapath and histogram_peak_top_n_unit

package hptn_pkg;

    localparam int VAL_W       = 16;
    localparam int IDX_W       = 9;
    localparam int KEEP_W      = 4;
    localparam int CNT_W       = 6;
    localparam int MAX_BINS    = 256;
    localparam int BIN_W       = $clog2(MAX_BINS);
    localparam int MAX_PEAKS_D = 8;

    localparam logic [KEEP_W-1:0] KEEP_RESET = KEEP_W'(5);

    typedef struct packed {
        logic [VAL_W-1:0] bin_value;
        logic             last_bin;
    } t_in_beat;

    typedef struct packed {
        logic [IDX_W-1:0] open_index;
        logic [IDX_W-1:0] close_index;
        logic [VAL_W-1:0] peak_value;
        logic             last_peak;
    } t_out_beat;

    // controller to datapath
    typedef struct packed {
        logic step;
        logic final_ins;
        logic load_out;
        logic last_beat;
        logic clear;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic             last;
        logic [CNT_W-1:0] count;
    } t_stat;

endpackage

/* src/hptn_datapath.sv */
// hptn_datapath: bin walk registers, sorted peak list and output register
// depends on hptn_pkg; driven by hptn_ctrl through hptn_pkg::t_cmd

module hptn_datapath #(
    parameter int MAX_PEAKS = hptn_pkg::MAX_PEAKS_D
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  hptn_pkg::t_cmd       i_cmd,
    input  hptn_pkg::t_in_beat   i_in,
    output hptn_pkg::t_stat      o_stat,
    output hptn_pkg::t_out_beat  o_out
);

    localparam int VAL_W = hptn_pkg::VAL_W;
    localparam int IDX_W = hptn_pkg::IDX_W;
    localparam int BIN_W = hptn_pkg::BIN_W;
    localparam int CNT_W = hptn_pkg::CNT_W;

    logic [BIN_W-1:0] r_bin_count;
    logic [VAL_W-1:0] r_prev, r_prev2;
    logic             r_seek;
    logic [IDX_W-1:0] r_open_lo;
    logic [VAL_W-1:0] r_open_h;
    logic [IDX_W-1:0] r_fin_hi;
    logic [CNT_W-1:0] r_count;
    hptn_pkg::t_out_beat r_out;

    logic [IDX_W-1:0] r_lo [MAX_PEAKS];
    logic [IDX_W-1:0] r_hi [MAX_PEAKS];
    logic [VAL_W-1:0] r_h  [MAX_PEAKS];

    logic [MAX_PEAKS-1:0] ge;
    logic [IDX_W-1:0]     center;
    logic [IDX_W-1:0]     ins_hi;
    logic                 valley_hit;
    logic                 top_hit;
    logic                 do_ins;
    logic                 n_seek;
    logic                 is_last;

    assign is_last    = i_in.last_bin || (r_bin_count == BIN_W'(hptn_pkg::MAX_BINS - 1));
    assign center     = IDX_W'(r_bin_count) - IDX_W'(1);
    assign valley_hit = (r_bin_count > BIN_W'(1)) && r_seek
                        && (r_prev2 > r_prev) && (i_in.bin_value > r_prev);
    assign top_hit    = (r_bin_count > BIN_W'(1)) && !r_seek
                        && (r_prev2 < r_prev) && (i_in.bin_value < r_prev);
    assign do_ins     = (i_cmd.step && valley_hit) || i_cmd.final_ins;
    assign ins_hi     = i_cmd.final_ins ? r_fin_hi : center;

    // seek flag as it stands after this bin
    always_comb begin
        n_seek = r_seek;
        if (r_bin_count == BIN_W'(1)) begin
            n_seek = r_prev > i_in.bin_value;
        end else if (valley_hit) begin
            n_seek = 1'b0;
        end else if (top_hit) begin
            n_seek = 1'b1;
        end
    end

    // list is sorted, so ge is a run of ones from entry 0
    always_comb begin
        for (int i = 0; i < MAX_PEAKS; i++) begin
            ge[i] = (CNT_W'(i) < r_count) && (r_h[i] >= r_open_h);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_bin_count <= '0;
            r_prev      <= '0;
            r_prev2     <= '0;
            r_seek      <= 1'b0;
            r_open_lo   <= '0;
            r_open_h    <= '0;
            r_count     <= '0;
        end else begin
            if (i_cmd.step) begin
                r_seek <= n_seek;
                if (r_bin_count == '0) begin
                    r_prev    <= i_in.bin_value;
                    r_open_lo <= '0;
                end else begin
                    r_prev2 <= r_prev;
                    r_prev  <= i_in.bin_value;
                end
                if (is_last && (r_bin_count == '0 || !n_seek)) begin
                    r_open_h <= i_in.bin_value;
                end else if (r_bin_count == '0) begin
                    r_open_h <= i_in.bin_value;
                end else if (r_bin_count == BIN_W'(1)) begin
                    r_open_h <= n_seek ? r_prev : '0;
                end else if (valley_hit) begin
                    r_open_h <= '0;
                end else if (top_hit) begin
                    r_open_h <= r_prev;
                end
                if (valley_hit) begin
                    r_open_lo <= center;
                end
                if (!is_last) begin
                    r_bin_count <= r_bin_count + BIN_W'(1);
                end
            end
            if (do_ins && r_count < CNT_W'(MAX_PEAKS)) begin
                r_count <= r_count + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_fin_hi <= IDX_W'(r_bin_count) + IDX_W'(1);
        end
        if (i_cmd.load_out) begin
            r_out.open_index  <= r_lo[0];
            r_out.close_index <= r_hi[0];
            r_out.peak_value  <= r_h[0];
            r_out.last_peak   <= i_cmd.last_beat;
        end
    end

    genvar g;
    generate
        for (g = 0; g < MAX_PEAKS; g++) begin : g_entry
            always_ff @(posedge i_clk) begin
                if (i_cmd.load_out) begin
                    // emit drains the list from the front
                    if (g < MAX_PEAKS - 1) begin
                        r_lo[g] <= r_lo[(g < MAX_PEAKS - 1) ? g + 1 : g];
                        r_hi[g] <= r_hi[(g < MAX_PEAKS - 1) ? g + 1 : g];
                        r_h[g]  <= r_h[(g < MAX_PEAKS - 1) ? g + 1 : g];
                    end
                end else if (do_ins && !ge[g]) begin
                    if (g == 0 || ge[(g > 0) ? g - 1 : 0]) begin
                        r_lo[g] <= r_open_lo;
                        r_hi[g] <= ins_hi;
                        r_h[g]  <= r_open_h;
                    end else begin
                        r_lo[g] <= r_lo[(g > 0) ? g - 1 : 0];
                        r_hi[g] <= r_hi[(g > 0) ? g - 1 : 0];
                        r_h[g]  <= r_h[(g > 0) ? g - 1 : 0];
                    end
                end
            end
        end
    endgenerate

    assign o_stat.last  = is_last;
    assign o_stat.count = r_count;
    assign o_out        = r_out;

endmodule

/* src/hptn_ctrl.sv */
// hptn_ctrl: run / final insert / emit sequencer, keep register, output valid
// depends on hptn_pkg; commands hptn_datapath

module hptn_ctrl #(
    parameter int MAX_PEAKS = hptn_pkg::MAX_PEAKS_D
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_out_stall,
    output logic                         o_out_valid,
    input  logic                         i_cfg_we,
    input  logic [hptn_pkg::KEEP_W-1:0]  i_cfg_data,
    input  hptn_pkg::t_stat              i_stat,
    output hptn_pkg::t_cmd               o_cmd
);

    localparam int CNT_W = hptn_pkg::CNT_W;

    typedef enum logic [2:0] {
        S_RUN   = 3'b001,
        S_FINAL = 3'b010,
        S_EMIT  = 3'b100
    } t_state;

    t_state                     r_state, n_state;
    logic [hptn_pkg::KEEP_W-1:0] r_keep;
    logic [CNT_W-1:0]           r_left, n_left;
    logic                       r_out_valid, n_out_valid;
    logic [CNT_W-1:0]           keep_eff;
    logic [CNT_W-1:0]           count_after;
    logic                       can_load;

    always_comb begin
        keep_eff = CNT_W'(r_keep);
        if (keep_eff == '0) begin
            keep_eff = CNT_W'(1);
        end
        if (keep_eff > CNT_W'(MAX_PEAKS)) begin
            keep_eff = CNT_W'(MAX_PEAKS);
        end
        count_after = (i_stat.count < CNT_W'(MAX_PEAKS))
                      ? i_stat.count + CNT_W'(1) : i_stat.count;
    end

    assign can_load = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_left      = r_left;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        case (r_state)
            S_RUN: begin
                o_cmd.step = i_in_valid;
                if (i_in_valid && i_stat.last) begin
                    n_state = S_FINAL;
                end
            end
            S_FINAL: begin
                o_cmd.final_ins = 1'b1;
                n_left  = (count_after < keep_eff) ? count_after : keep_eff;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (can_load) begin
                    o_cmd.load_out  = 1'b1;
                    o_cmd.last_beat = (r_left == CNT_W'(1));
                    o_cmd.clear     = (r_left == CNT_W'(1));
                    n_out_valid     = 1'b1;
                    n_left          = r_left - CNT_W'(1);
                    if (r_left == CNT_W'(1)) begin
                        n_state = S_RUN;
                    end
                end
            end
            default: begin
                n_state = S_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_RUN;
            r_left      <= '0;
            r_out_valid <= 1'b0;
            r_keep      <= hptn_pkg::KEEP_RESET;
        end else begin
            r_state     <= n_state;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_keep <= i_cfg_data;
            end
        end
    end

    assign o_in_stall  = (r_state != S_RUN);
    assign o_out_valid = r_out_valid;

endmodule

/* src/histogram_peak_top_n_unit.sv */
// histogram_peak_top_n_unit: top level of the histogram peak finder
// depends on hptn_pkg, hptn_ctrl and hptn_datapath
//
// Usage: histogram bins stream in on the input channel (i_in_valid, i_in_data,
// o_in_stall), bin 0 first, last_bin set on the final bin. Bins past the
// MAX_BINS limit are cut off: bin MAX_BINS-1 always closes the histogram.
// Non-final bins are taken one per cycle, back to back.
// After the final bin the input stalls: the S_FINAL state inserts the closing
// peak into the sorted list, then the highest peaks leave on the output
// channel (o_out_valid, o_out_data, i_out_stall), highest first, one beat a
// cycle while the receiver does not stall, last_peak set on the final beat.
// The first beat is loaded into the output register in S_EMIT, after S_FINAL.
// The output register holds a stalled beat and the list drains only as beats
// are taken. peaks_to_keep is written through i_cfg_we / i_cfg_data; the user
// must write it only while idle, the block itself does not enforce this.
// Reset (synchronous, active low) clears the walk and sets peaks_to_keep to 5.

module histogram_peak_top_n_unit #(
    parameter int MAX_PEAKS = hptn_pkg::MAX_PEAKS_D
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  hptn_pkg::t_in_beat           i_in_data,
    output logic                         o_in_stall,
    output logic                         o_out_valid,
    output hptn_pkg::t_out_beat          o_out_data,
    input  logic                         i_out_stall,
    input  logic                         i_cfg_we,
    input  logic [hptn_pkg::KEEP_W-1:0]  i_cfg_data
);

    hptn_pkg::t_cmd  w_cmd;
    hptn_pkg::t_stat w_stat;

    hptn_ctrl #(
        .MAX_PEAKS (MAX_PEAKS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    hptn_datapath #(
        .MAX_PEAKS (MAX_PEAKS)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_in    (i_in_data),
        .o_stat  (w_stat),
        .o_out   (o_out_data)
    );

    // a final bin always hands over to the insert and emit phases
    a_last_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && w_stat.last) |=> o_in_stall)
        else $error("input not stalled after final bin");

    // a held beat is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |-> !(o_out_valid && i_out_stall))
        else $error("output register loaded while stalled");

    // bin walk, insert and drain never overlap
    a_cmd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.step |-> (!w_cmd.final_ins && !w_cmd.load_out))
        else $error("conflicting datapath commands");

    // the closing insert leaves at least one peak to report
    a_list_filled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.final_ins |=> (w_stat.count != '0))
        else $error("peak list empty after closing insert");

endmodule
